// ===== rtl/lca_pkg.sv =====
// lca_pkg: shared widths, constants and memory request types for the
// binary lifting common ancestor engine. No dependencies.
`timescale 1ns / 1ps
package lca_pkg;

    localparam int NODE_W = 10;              // real node index width
    localparam int ID_W   = NODE_W + 1;      // node index including the dummy
    localparam int LEVELS = 10;              // ancestor levels per row
    localparam int LVL_W  = 4;               // level index width
    localparam int DEP_W  = 11;              // signed depth width
    localparam int DIST_W = 10;

    localparam logic [ID_W-1:0] DUMMY = ID_W'(1 << NODE_W);
    localparam logic signed [DEP_W-1:0] DEP_NONE = -DEP_W'(1);
    localparam logic signed [DEP_W-1:0] DEP_MAX  = DEP_W'((1 << NODE_W) - 1);
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_LCA   = 2'd1;
    localparam logic [1:0] REQ_CLIMB = 2'd2;

    typedef logic [ID_W-1:0] id_t;
    typedef logic signed [DEP_W-1:0] dep_t;

    typedef struct packed {
        logic              rd_en;
        id_t               rd_node;
        logic [LVL_W-1:0]  rd_lvl;
        logic              wr_en;
        logic [NODE_W-1:0] wr_node;
        logic [LVL_W-1:0]  wr_lvl;
        id_t               wr_data;
    } anc_req_t;

    typedef struct packed {
        logic              rd_en;
        id_t               rd_node;
        logic              wr_en;
        logic [NODE_W-1:0] wr_node;
        dep_t              wr_data;
    } dep_req_t;

endpackage

// ===== rtl/lca_anc_ram.sv =====
// lca_anc_ram: ancestor table, one row of levels per node, registered read.
// The dummy row is not stored; a read of it returns the dummy. Uses lca_pkg.
`timescale 1ns / 1ps
module lca_anc_ram (
    input  logic              clk,
    input  lca_pkg::anc_req_t req,
    output lca_pkg::id_t      rdata
);
    import lca_pkg::*;

    id_t  mem [0:(1 << (NODE_W + LVL_W)) - 1];
    id_t  q_reg;
    logic dmy_reg;

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[{req.wr_node, req.wr_lvl}] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg   <= mem[{req.rd_node[NODE_W-1:0], req.rd_lvl}];
            dmy_reg <= req.rd_node[ID_W-1];
        end
    end

    assign rdata = dmy_reg ? DUMMY : q_reg;

endmodule

// ===== rtl/lca_dep_ram.sv =====
// lca_dep_ram: node depth table, registered read; the dummy reads as -1.
// Uses lca_pkg.
`timescale 1ns / 1ps
module lca_dep_ram (
    input  logic              clk,
    input  lca_pkg::dep_req_t req,
    output lca_pkg::dep_t     rdata
);
    import lca_pkg::*;

    dep_t mem [0:(1 << NODE_W) - 1];
    dep_t q_reg;
    logic dmy_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_node] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg   <= mem[req.rd_node[NODE_W-1:0]];
            dmy_reg <= req.rd_node[ID_W-1];
        end
    end

    assign rdata = dmy_reg ? DEP_NONE : q_reg;

endmodule

// ===== rtl/lca_seq.sv =====
// lca_seq: sequencer that runs loads, common ancestor and climb queries
// through the ancestor and depth memories. Uses lca_pkg.
`timescale 1ns / 1ps
module lca_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  req_type,
    input  logic [lca_pkg::NODE_W-1:0]  node_a,
    input  logic [lca_pkg::NODE_W-1:0]  node_b,
    input  logic                        is_root,
    input  logic [lca_pkg::DIST_W-1:0]  distance,
    output logic                        idle,
    output logic                        res_valid,
    output lca_pkg::id_t                res_id,
    input  logic                        res_taken,
    output lca_pkg::anc_req_t           anc_req,
    input  lca_pkg::id_t                anc_rdata,
    output lca_pkg::dep_req_t           dep_req,
    input  lca_pkg::dep_t               dep_rdata
);
    import lca_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_R_WR  = 5'd1;
    localparam logic [4:0] S_L_DEP = 5'd2;
    localparam logic [4:0] S_L_RD  = 5'd3;
    localparam logic [4:0] S_L_WT  = 5'd4;
    localparam logic [4:0] S_Q_DA  = 5'd5;
    localparam logic [4:0] S_Q_DB  = 5'd6;
    localparam logic [4:0] S_P1_A  = 5'd7;
    localparam logic [4:0] S_P1_B  = 5'd8;
    localparam logic [4:0] S_P1_C  = 5'd9;
    localparam logic [4:0] S_CMP   = 5'd10;
    localparam logic [4:0] S_P2_A  = 5'd11;
    localparam logic [4:0] S_P2_B  = 5'd12;
    localparam logic [4:0] S_P2_C  = 5'd13;
    localparam logic [4:0] S_FIN   = 5'd14;
    localparam logic [4:0] S_FIN_W = 5'd15;
    localparam logic [4:0] S_K_DEP = 5'd16;
    localparam logic [4:0] S_K_A   = 5'd17;
    localparam logic [4:0] S_K_B   = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    logic [4:0]        state_reg, state_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [NODE_W-1:0] a_reg, a_next;
    id_t               b_reg, b_next;
    logic [DIST_W-1:0] k_reg, k_next;
    id_t               u_reg, u_next;
    id_t               v_reg, v_next;
    id_t               up_reg, up_next;
    id_t               res_reg, res_next;
    dep_t              du_reg, du_next;
    dep_t              dv_reg, dv_next;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        lvl_reg  <= lvl_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        k_reg    <= k_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        up_reg   <= up_next;
        res_reg  <= res_next;
        du_reg   <= du_next;
        dv_reg   <= dv_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_id    = res_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        up_next    = up_reg;
        res_next   = res_reg;
        du_next    = du_reg;
        dv_next    = dv_reg;
        anc_req    = '0;
        dep_req    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next    = node_a;
                    b_next    = {1'b0, node_b};
                    k_next    = distance;
                    lvl_next  = '0;
                    case (req_type) inside
                        REQ_LOAD:
                        begin
                            if (is_root)
                            begin
                                state_next = S_R_WR;
                            end
                            else
                            begin
                                dep_req.rd_en   = 1'b1;
                                dep_req.rd_node = {1'b0, node_b};
                                state_next      = S_L_DEP;
                            end
                        end
                        REQ_LCA, REQ_CLIMB:
                        begin
                            dep_req.rd_en   = 1'b1;
                            dep_req.rd_node = {1'b0, node_a};
                            state_next      = (req_type == REQ_LCA) ? S_Q_DA : S_K_DEP;
                        end
                        default:
                        begin
                            res_next   = DUMMY;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // root load: depth 0, every level points at the dummy
            S_R_WR:
            begin
                dep_req.wr_en   = (lvl_reg == '0);
                dep_req.wr_node = a_reg;
                dep_req.wr_data = '0;
                anc_req.wr_en   = 1'b1;
                anc_req.wr_node = a_reg;
                anc_req.wr_lvl  = lvl_reg;
                anc_req.wr_data = DUMMY;
                if (lvl_reg == LVL_TOP)
                begin
                    res_next   = {1'b0, a_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end

            // child load: depth from parent, level 0 is the parent
            S_L_DEP:
            begin
                dep_req.wr_en   = 1'b1;
                dep_req.wr_node = a_reg;
                dep_req.wr_data = (dep_rdata >= DEP_MAX) ? DEP_MAX : dep_rdata + 1'b1;
                anc_req.wr_en   = 1'b1;
                anc_req.wr_node = a_reg;
                anc_req.wr_lvl  = '0;
                anc_req.wr_data = b_reg;
                u_next          = b_reg;
                if (LVL_TOP == '0)
                begin
                    res_next   = {1'b0, a_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next   = LVL_W'(1);
                    state_next = S_L_RD;
                end
            end

            S_L_RD:
            begin
                anc_req.rd_en   = 1'b1;
                anc_req.rd_node = u_reg;
                anc_req.rd_lvl  = lvl_reg - 1'b1;
                state_next      = S_L_WT;
            end

            S_L_WT:
            begin
                u_next          = anc_rdata;
                anc_req.wr_en   = 1'b1;
                anc_req.wr_node = a_reg;
                anc_req.wr_lvl  = lvl_reg;
                anc_req.wr_data = anc_rdata;
                if (lvl_reg == LVL_TOP)
                begin
                    res_next   = {1'b0, a_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_L_RD;
                end
            end

            // common ancestor: fetch both depths
            S_Q_DA:
            begin
                du_next         = dep_rdata;
                dep_req.rd_en   = 1'b1;
                dep_req.rd_node = b_reg;
                state_next      = S_Q_DB;
            end

            S_Q_DB:
            begin
                if (du_reg < dep_rdata)
                begin
                    u_next  = b_reg;
                    v_next  = {1'b0, a_reg};
                    dv_next = du_reg;
                end
                else
                begin
                    u_next  = {1'b0, a_reg};
                    v_next  = b_reg;
                    dv_next = dep_rdata;
                end
                lvl_next   = LVL_TOP;
                state_next = S_P1_A;
            end

            // first pass: lift the deeper node to the other's depth
            S_P1_A:
            begin
                anc_req.rd_en   = 1'b1;
                anc_req.rd_node = u_reg;
                anc_req.rd_lvl  = lvl_reg;
                state_next      = S_P1_B;
            end

            S_P1_B:
            begin
                up_next         = anc_rdata;
                dep_req.rd_en   = 1'b1;
                dep_req.rd_node = anc_rdata;
                state_next      = S_P1_C;
            end

            S_P1_C:
            begin
                if (dep_rdata >= dv_reg)
                begin
                    u_next = up_reg;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_P1_A;
                end
            end

            S_CMP:
            begin
                if (u_reg == v_reg)
                begin
                    res_next   = u_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next   = LVL_TOP;
                    state_next = S_P2_A;
                end
            end

            // second pass: lift both while their ancestors differ
            S_P2_A:
            begin
                anc_req.rd_en   = 1'b1;
                anc_req.rd_node = u_reg;
                anc_req.rd_lvl  = lvl_reg;
                state_next      = S_P2_B;
            end

            S_P2_B:
            begin
                up_next         = anc_rdata;
                anc_req.rd_en   = 1'b1;
                anc_req.rd_node = v_reg;
                anc_req.rd_lvl  = lvl_reg;
                state_next      = S_P2_C;
            end

            S_P2_C:
            begin
                if (up_reg != anc_rdata)
                begin
                    u_next = up_reg;
                    v_next = anc_rdata;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_P2_A;
                end
            end

            S_FIN:
            begin
                anc_req.rd_en   = 1'b1;
                anc_req.rd_node = u_reg;
                anc_req.rd_lvl  = '0;
                state_next      = S_FIN_W;
            end

            S_FIN_W:
            begin
                res_next   = anc_rdata;
                state_next = S_DONE;
            end

            // climb: reject distances beyond the depth
            S_K_DEP:
            begin
                if ($signed({2'b00, k_reg}) > $signed({dep_rdata[DEP_W-1], dep_rdata}))
                begin
                    res_next   = DUMMY;
                    state_next = S_DONE;
                end
                else
                begin
                    u_next     = {1'b0, a_reg};
                    lvl_next   = LVL_TOP;
                    state_next = S_K_A;
                end
            end

            S_K_A:
            begin
                if (k_reg[lvl_reg])
                begin
                    anc_req.rd_en   = 1'b1;
                    anc_req.rd_node = u_reg;
                    anc_req.rd_lvl  = lvl_reg;
                    state_next      = S_K_B;
                end
                else if (lvl_reg == '0)
                begin
                    res_next   = u_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end

            S_K_B:
            begin
                u_next = anc_rdata;
                if (lvl_reg == '0)
                begin
                    res_next   = anc_rdata;
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_K_A;
                end
            end

            S_DONE:
            begin
                if (res_taken)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/binary_lifting_lca_engine_core.sv =====
// binary_lifting_lca_engine_core: top level; sequencer, the two table
// memories and the result register. Uses lca_pkg, lca_seq and the RAMs.
`timescale 1ns / 1ps
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_ready  | req_type node_a node_b is_root distance
//  out     | out_valid/out_ready| result_node found
//
//  One item at a time. A child load makes one ancestor memory read-then-write
//  pair per level. Common ancestor: each level of each pass makes two table
//  reads, then the compare.
//  A new item is taken while the previous result waits in the output register.
//  Reset clears control only; table contents need no clearing.
module binary_lifting_lca_engine_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic [lca_pkg::NODE_W-1:0]  node_a,
    input  logic [lca_pkg::NODE_W-1:0]  node_b,
    input  logic                        is_root,
    input  logic [lca_pkg::DIST_W-1:0]  distance,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lca_pkg::NODE_W-1:0]  result_node,
    output logic                        found
);
    import lca_pkg::*;

    logic              idle;
    logic              res_valid;
    logic              res_taken;
    id_t               res_id;
    anc_req_t          anc_req;
    id_t               anc_rdata;
    dep_req_t          dep_req;
    dep_t              dep_rdata;
    logic              out_valid_reg;
    logic [NODE_W-1:0] result_reg;
    logic              found_reg;

    assign in_ready  = idle;
    assign res_taken = res_valid && (!out_valid_reg || out_ready);

    lca_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && idle),
        .req_type  (req_type),
        .node_a    (node_a),
        .node_b    (node_b),
        .is_root   (is_root),
        .distance  (distance),
        .idle      (idle),
        .res_valid (res_valid),
        .res_id    (res_id),
        .res_taken (res_taken),
        .anc_req   (anc_req),
        .anc_rdata (anc_rdata),
        .dep_req   (dep_req),
        .dep_rdata (dep_rdata)
    );

    lca_anc_ram u_anc (
        .clk   (clk),
        .req   (anc_req),
        .rdata (anc_rdata)
    );

    lca_dep_ram u_dep (
        .clk   (clk),
        .req   (dep_req),
        .rdata (dep_rdata)
    );

    // output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_taken)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register: payload, dummy maps to not found
    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            result_reg <= res_id[ID_W-1] ? '0 : res_id[NODE_W-1:0];
            found_reg  <= !res_id[ID_W-1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_node = result_reg;
    assign found       = found_reg;

endmodule
